// File: rtl/core/frdr_pkg.sv
// ============================================================================
// frdr_pkg
// Shared types, constants and helpers for the dielectric Fresnel reflectance
// pipeline.
// ============================================================================
package frdr_pkg;

    // Fixed-point formats
    localparam int COS_W       = 16;
    localparam int COS_FRAC_BITS = 14;
    localparam int IDX_W       = 16;
    localparam int REFL_W      = 16;
    localparam int C_W         = 17;  // |cos| in Q0.16, up to 1.0
    localparam int COS_ONE     = 1 << COS_FRAC_BITS;
    localparam int COS_SHL     = (COS_FRAC_BITS < 16) ? 16 - COS_FRAC_BITS : 0;
    localparam int COS_SHR     = (COS_FRAC_BITS > 16) ? COS_FRAC_BITS - 16 : 0;
    localparam int COS_HALF    = (1 << COS_SHR) >> 1;

    // Configuration register map
    localparam int CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] REG_INDEX_INCIDENT    = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INDEX_TRANSMITTED = 8'd1;
    localparam logic [IDX_W-1:0]     RST_INDEX_INCIDENT    = 16'd4096;
    localparam logic [IDX_W-1:0]     RST_INDEX_TRANSMITTED = 16'd6144;

    // Result constants
    localparam logic [REFL_W-1:0] REFL_ONE = 16'd32768;

    // Back-end sizes
    localparam int RT_STAGES  = 32;   // one result bit of the square root per stage
    localparam int DIV_STAGES = 32;   // one quotient bit per stage
    localparam int NUM_W      = 50;   // ratio numerator/denominator before normalizing
    localparam int NRM_W      = 31;   // after normalizing, below 2^31
    localparam int SHF_W      = 5;

    // Queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = 2;

    // One classified item handed from front to back
    typedef struct packed {
        logic              tir;
        logic [63:0]       diff;   // nt^2*2^32 - ni^2*sinI^2
        logic [C_W-1:0]    c;
        logic [IDX_W-1:0]  ni;
        logic [31:0]       nt2;
    } t_entry;

    // Per-item values that ride along the square root stages
    typedef struct packed {
        logic              tir;
        logic [C_W-1:0]    c;
        logic [IDX_W-1:0]  ni;
        logic [31:0]       nt2;
    } t_side;

    // Bring |cos| to Q0.16, rounding half up when narrowing, clamped to 1.0
    function automatic logic [C_W-1:0] to_q16(input logic [31:0] m);
        logic [47:0] w;
        w = {16'b0, m} << COS_SHL;
        w = (w + 48'(COS_HALF)) >> COS_SHR;
        if (w > 48'd65536) begin
            w = 48'd65536;
        end
        return w[C_W-1:0];
    endfunction

endpackage

// File: rtl/core/frdr_if.sv
// ============================================================================
// frdr_if
// Valid/ready channels of the Fresnel reflectance block: input item, result
// item and configuration write.
// ============================================================================
interface frdr_item_if;
    logic                              valid;
    logic                              ready;
    logic signed [frdr_pkg::COS_W-1:0] cos_incident;

    modport source (output valid, output cos_incident, input ready);
    modport sink   (input valid, input cos_incident, output ready);
endinterface

interface frdr_result_if;
    logic                         valid;
    logic                         ready;
    logic [frdr_pkg::REFL_W-1:0]  reflectance;
    logic                         total_internal;

    modport source (output valid, output reflectance, output total_internal, input ready);
    modport sink   (input valid, input reflectance, input total_internal, output ready);
endinterface

interface frdr_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [frdr_pkg::CFG_IDX_W-1:0] index;
    logic [frdr_pkg::IDX_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/core/frdr_front.sv
// ============================================================================
// frdr_front
// Holds the index registers, clamps the cosine, swaps indices for exiting
// rays and classifies total internal reflection over three stages.
// ============================================================================
module frdr_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    frdr_item_if.sink           i_item,
    frdr_cfg_if.sink            i_cfg,
    input  logic                i_q_full,
    output logic                o_push,
    output frdr_pkg::t_entry    o_entry
);

    logic [frdr_pkg::IDX_W-1:0] r_index_incident;
    logic [frdr_pkg::IDX_W-1:0] r_index_transmitted;

    logic                        f_adv;
    logic                        r_a_valid, r_b_valid, r_c_valid;
    logic [frdr_pkg::C_W-1:0]    r_a_c, r_b_c;
    logic [frdr_pkg::IDX_W-1:0]  r_a_ni, r_a_nt, r_b_ni;
    logic [31:0]                 r_b_ni2, r_b_nt2;
    logic [32:0]                 r_b_sin2;
    frdr_pkg::t_entry            r_c_entry;

    logic [frdr_pkg::C_W-1:0]    n_a_c;
    logic [frdr_pkg::IDX_W-1:0]  n_a_ni, n_a_nt;
    logic [64:0]                 lhs;
    logic [63:0]                 rhs;
    frdr_pkg::t_entry            n_c_entry;

    // Write configuration registers
    assign i_cfg.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_index_incident    <= frdr_pkg::RST_INDEX_INCIDENT;
            r_index_transmitted <= frdr_pkg::RST_INDEX_TRANSMITTED;
        end else if (i_cfg.valid) begin
            if (i_cfg.index == frdr_pkg::REG_INDEX_INCIDENT) begin
                r_index_incident <= i_cfg.data;
            end else if (i_cfg.index == frdr_pkg::REG_INDEX_TRANSMITTED) begin
                r_index_transmitted <= i_cfg.data;
            end
        end
    end

    // Advance the whole front unless the last stage is blocked by a full queue
    assign f_adv        = !r_c_valid || !i_q_full;
    assign i_item.ready = f_adv;
    assign o_push       = r_c_valid && !i_q_full;
    assign o_entry      = r_c_entry;

    // Stage A: clamp, pick side, take magnitude
    always_comb begin
        int cs;
        int mag;
        cs = int'(i_item.cos_incident);
        if (cs > frdr_pkg::COS_ONE) begin
            cs = frdr_pkg::COS_ONE;
        end
        if (cs < -frdr_pkg::COS_ONE) begin
            cs = -frdr_pkg::COS_ONE;
        end
        if (cs > 0) begin
            n_a_ni = r_index_incident;
            n_a_nt = r_index_transmitted;
            mag    = cs;
        end else begin
            n_a_ni = r_index_transmitted;
            n_a_nt = r_index_incident;
            mag    = -cs;
        end
        n_a_c = frdr_pkg::to_q16(32'(mag));
    end

    // Stage C: compare ni^2*sinI^2 against nt^2
    always_comb begin
        lhs = {33'b0, r_b_ni2} * {32'b0, r_b_sin2};
        rhs = {r_b_nt2, 32'b0};
        n_c_entry.tir  = (lhs >= {1'b0, rhs});
        n_c_entry.diff = rhs - lhs[63:0];
        n_c_entry.c    = r_b_c;
        n_c_entry.ni   = r_b_ni;
        n_c_entry.nt2  = r_b_nt2;
    end

    // Advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else if (f_adv) begin
            r_a_valid <= i_item.valid;
            r_b_valid <= r_a_valid;
            r_c_valid <= r_b_valid;
        end
    end

    // Advance payload
    always_ff @(posedge i_clk) begin
        if (f_adv) begin
            r_a_c     <= n_a_c;
            r_a_ni    <= n_a_ni;
            r_a_nt    <= n_a_nt;
            r_b_c     <= r_a_c;
            r_b_ni    <= r_a_ni;
            r_b_ni2   <= 32'(r_a_ni) * 32'(r_a_ni);
            r_b_nt2   <= 32'(r_a_nt) * 32'(r_a_nt);
            r_b_sin2  <= 33'h1_0000_0000 - (33'(r_a_c) * 33'(r_a_c));
            r_c_entry <= n_c_entry;
        end
    end

endmodule

// File: rtl/core/frdr_queue.sv
// ============================================================================
// frdr_queue
// Small register FIFO between the classifying front and the arithmetic back.
// ============================================================================
module frdr_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  frdr_pkg::t_entry  i_entry,
    input  logic              i_pop,
    output logic              o_full,
    output logic              o_empty,
    output frdr_pkg::t_entry  o_head
);

    frdr_pkg::t_entry              r_mem [frdr_pkg::Q_DEPTH];
    logic [frdr_pkg::Q_PTR_W-1:0]  r_wr_ptr, r_rd_ptr;
    logic [frdr_pkg::Q_PTR_W:0]    r_count;

    assign o_full  = (r_count == (frdr_pkg::Q_PTR_W+1)'(frdr_pkg::Q_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];

    // Store pushed entries
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    // Move pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// File: rtl/core/frdr_div.sv
// ============================================================================
// frdr_div
// Pipelined restoring divider: floor(num * 2^31 / den) for num <= den,
// one quotient bit per stage.
// ============================================================================
module frdr_div (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [frdr_pkg::NRM_W-1:0]  i_num,
    input  logic [frdr_pkg::NRM_W-1:0]  i_den,
    output logic [31:0]                 o_quo
);

    logic [31:0]                 r_rem [frdr_pkg::DIV_STAGES];
    logic [31:0]                 r_quo [frdr_pkg::DIV_STAGES];
    logic [frdr_pkg::NRM_W-1:0]  r_den [frdr_pkg::DIV_STAGES];

    for (genvar j = 0; j < frdr_pkg::DIV_STAGES; j++) begin : g_stage
        logic [31:0]                rem_in, quo_in, sh, n_rem;
        logic [frdr_pkg::NRM_W-1:0] den_in;
        logic                       q_bit;

        // Pick the stage inputs; the first stage takes the top bit unshifted
        if (j == 0) begin : g_first
            assign rem_in = {1'b0, i_num};
            assign quo_in = '0;
            assign den_in = i_den;
            assign sh     = rem_in;
        end else begin : g_next
            assign rem_in = r_rem[j-1];
            assign quo_in = r_quo[j-1];
            assign den_in = r_den[j-1];
            assign sh     = {rem_in[30:0], 1'b0};
        end

        // Compare and subtract
        assign q_bit = (sh >= {1'b0, den_in});
        assign n_rem = q_bit ? sh - {1'b0, den_in} : sh;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[j] <= n_rem;
                r_quo[j] <= {quo_in[30:0], q_bit};
                r_den[j] <= den_in;
            end
        end
    end

    assign o_quo = r_quo[frdr_pkg::DIV_STAGES-1];

endmodule

// File: rtl/core/frdr_back.sv
// ============================================================================
// frdr_back
// Arithmetic back end: pipelined square root for nt*cosT, both amplitude
// ratios through normalizing and pipelined dividers, squares and the mean.
// ============================================================================
module frdr_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_empty,
    input  frdr_pkg::t_entry  i_head,
    output logic              o_pop,
    frdr_result_if.source     o_result
);

    logic b_adv;

    // Entry stage
    logic              r_s0_vld;
    frdr_pkg::t_entry  r_s0;

    // Square root stages
    logic              r_rt_vld  [frdr_pkg::RT_STAGES];
    logic [63:0]       r_rt_v    [frdr_pkg::RT_STAGES];
    logic [63:0]       r_rt_res  [frdr_pkg::RT_STAGES];
    frdr_pkg::t_side   r_rt_side [frdr_pkg::RT_STAGES];

    // Product, ratio, normalize stages
    logic                        r_m_vld, r_d_vld, r_k_vld, r_n_vld;
    logic                        r_m_tir, r_d_tir, r_k_tir, r_n_tir;
    logic [48:0]                 r_m_p1;
    logic [47:0]                 r_m_q1;
    logic [32:0]                 r_m_p2;
    logic [31:0]                 r_m_q2;
    logic [frdr_pkg::NUM_W-1:0]  r_d_num1, r_d_den1, r_d_num2, r_d_den2;
    logic [frdr_pkg::NUM_W-1:0]  r_k_num1, r_k_den1, r_k_num2, r_k_den2;
    logic [frdr_pkg::SHF_W-1:0]  r_k_sh1, r_k_sh2, n_k_sh1, n_k_sh2;
    logic [frdr_pkg::NRM_W-1:0]  r_n_num1, r_n_den1, r_n_num2, r_n_den2;
    logic [frdr_pkg::NRM_W-1:0]  n_n_num1, n_n_den1, n_n_num2, n_n_den2;

    // Divider side pipe, squares and output
    logic        r_dv_vld [frdr_pkg::DIV_STAGES];
    logic        r_dv_tir [frdr_pkg::DIV_STAGES];
    logic [31:0] quo1, quo2;
    logic        r_sq_vld, r_sq_tir;
    logic [63:0] r_sq1, r_sq2;
    logic        r_o_vld, r_o_tir;
    logic [frdr_pkg::REFL_W-1:0] r_o_refl, n_o_refl;
    logic [64:0] sum;
    logic [16:0] rnd;

    // Move the whole back end unless the output beat is held
    assign b_adv = !r_o_vld || o_result.ready;
    assign o_pop = b_adv && !i_q_empty;

    // Entry stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_vld <= 1'b0;
        end else if (b_adv) begin
            r_s0_vld <= !i_q_empty;
        end
    end
    always_ff @(posedge i_clk) begin
        if (b_adv) begin
            r_s0 <= i_head;
        end
    end

    // Square root, one result bit per stage
    for (genvar j = 0; j < frdr_pkg::RT_STAGES; j++) begin : g_rt
        localparam logic [63:0] BIT = 64'(1) << (2 * (frdr_pkg::RT_STAGES - 1 - j));
        logic            vld_in;
        logic [63:0]     v_in, res_in, trial, n_v, n_res;
        frdr_pkg::t_side side_in;

        if (j == 0) begin : g_first
            assign vld_in  = r_s0_vld;
            assign v_in    = r_s0.diff;
            assign res_in  = '0;
            assign side_in = '{tir: r_s0.tir, c: r_s0.c, ni: r_s0.ni, nt2: r_s0.nt2};
        end else begin : g_next
            assign vld_in  = r_rt_vld[j-1];
            assign v_in    = r_rt_v[j-1];
            assign res_in  = r_rt_res[j-1];
            assign side_in = r_rt_side[j-1];
        end

        // Try subtracting res + bit
        always_comb begin
            trial = res_in + BIT;
            if (v_in >= trial) begin
                n_v   = v_in - trial;
                n_res = (res_in >> 1) + BIT;
            end else begin
                n_v   = v_in;
                n_res = res_in >> 1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_rt_vld[j] <= 1'b0;
            end else if (b_adv) begin
                r_rt_vld[j] <= vld_in;
            end
        end
        always_ff @(posedge i_clk) begin
            if (b_adv) begin
                r_rt_v[j]    <= n_v;
                r_rt_res[j]  <= n_res;
                r_rt_side[j] <= side_in;
            end
        end
    end

    // Find right shift that brings a denominator below 2^31
    function automatic logic [frdr_pkg::SHF_W-1:0] norm_shift(
        input logic [frdr_pkg::NUM_W-1:0] den
    );
        logic [frdr_pkg::SHF_W-1:0] k;
        k = '0;
        for (int b = frdr_pkg::NRM_W; b < frdr_pkg::NUM_W; b++) begin
            if (den[b]) begin
                k = frdr_pkg::SHF_W'(b - frdr_pkg::NRM_W + 1);
            end
        end
        return k;
    endfunction

    always_comb begin
        n_k_sh1 = norm_shift(r_d_den1);
        n_k_sh2 = norm_shift(r_d_den2);
    end

    // Shift, then guard zero denominators and clamp the numerator
    always_comb begin
        logic [frdr_pkg::NUM_W-1:0] t_num1, t_den1, t_num2, t_den2;
        t_num1   = r_k_num1 >> r_k_sh1;
        t_den1   = r_k_den1 >> r_k_sh1;
        t_num2   = r_k_num2 >> r_k_sh2;
        t_den2   = r_k_den2 >> r_k_sh2;
        n_n_num1 = t_num1[frdr_pkg::NRM_W-1:0];
        n_n_den1 = t_den1[frdr_pkg::NRM_W-1:0];
        n_n_num2 = t_num2[frdr_pkg::NRM_W-1:0];
        n_n_den2 = t_den2[frdr_pkg::NRM_W-1:0];
        if (n_n_den1 == '0) begin
            n_n_num1 = frdr_pkg::NRM_W'(1);
            n_n_den1 = frdr_pkg::NRM_W'(1);
        end else if (n_n_num1 > n_n_den1) begin
            n_n_num1 = n_n_den1;
        end
        if (n_n_den2 == '0) begin
            n_n_num2 = frdr_pkg::NRM_W'(1);
            n_n_den2 = frdr_pkg::NRM_W'(1);
        end else if (n_n_num2 > n_n_den2) begin
            n_n_num2 = n_n_den2;
        end
    end

    // Valid bits of the middle stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_vld <= 1'b0;
            r_d_vld <= 1'b0;
            r_k_vld <= 1'b0;
            r_n_vld <= 1'b0;
        end else if (b_adv) begin
            r_m_vld <= r_rt_vld[frdr_pkg::RT_STAGES-1];
            r_d_vld <= r_m_vld;
            r_k_vld <= r_d_vld;
            r_n_vld <= r_k_vld;
        end
    end

    // Products, then |p - q| and p + q, then normalize
    always_ff @(posedge i_clk) begin
        if (b_adv) begin
            r_m_tir  <= r_rt_side[frdr_pkg::RT_STAGES-1].tir;
            r_m_p1   <= 49'(r_rt_side[frdr_pkg::RT_STAGES-1].nt2)
                        * 49'(r_rt_side[frdr_pkg::RT_STAGES-1].c);
            r_m_q1   <= 48'(r_rt_side[frdr_pkg::RT_STAGES-1].ni)
                        * 48'(r_rt_res[frdr_pkg::RT_STAGES-1][31:0]);
            r_m_p2   <= 33'(r_rt_side[frdr_pkg::RT_STAGES-1].ni)
                        * 33'(r_rt_side[frdr_pkg::RT_STAGES-1].c);
            r_m_q2   <= r_rt_res[frdr_pkg::RT_STAGES-1][31:0];

            r_d_tir  <= r_m_tir;
            r_d_num1 <= (50'(r_m_p1) > 50'(r_m_q1)) ? 50'(r_m_p1) - 50'(r_m_q1)
                                                    : 50'(r_m_q1) - 50'(r_m_p1);
            r_d_den1 <= 50'(r_m_p1) + 50'(r_m_q1);
            r_d_num2 <= (50'(r_m_p2) > 50'(r_m_q2)) ? 50'(r_m_p2) - 50'(r_m_q2)
                                                    : 50'(r_m_q2) - 50'(r_m_p2);
            r_d_den2 <= 50'(r_m_p2) + 50'(r_m_q2);

            r_k_tir  <= r_d_tir;
            r_k_num1 <= r_d_num1;
            r_k_den1 <= r_d_den1;
            r_k_num2 <= r_d_num2;
            r_k_den2 <= r_d_den2;
            r_k_sh1  <= n_k_sh1;
            r_k_sh2  <= n_k_sh2;

            r_n_tir  <= r_k_tir;
            r_n_num1 <= n_n_num1;
            r_n_den1 <= n_n_den1;
            r_n_num2 <= n_n_num2;
            r_n_den2 <= n_n_den2;
        end
    end

    // Both ratios through their dividers
    frdr_div u_div_par (
        .i_clk (i_clk),
        .i_en  (b_adv),
        .i_num (r_n_num1),
        .i_den (r_n_den1),
        .o_quo (quo1)
    );

    frdr_div u_div_perp (
        .i_clk (i_clk),
        .i_en  (b_adv),
        .i_num (r_n_num2),
        .i_den (r_n_den2),
        .o_quo (quo2)
    );

    // Carry valid and flag alongside the dividers
    for (genvar j = 0; j < frdr_pkg::DIV_STAGES; j++) begin : g_dv
        logic vld_in, tir_in;
        if (j == 0) begin : g_first
            assign vld_in = r_n_vld;
            assign tir_in = r_n_tir;
        end else begin : g_next
            assign vld_in = r_dv_vld[j-1];
            assign tir_in = r_dv_tir[j-1];
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_vld[j] <= 1'b0;
            end else if (b_adv) begin
                r_dv_vld[j] <= vld_in;
            end
        end
        always_ff @(posedge i_clk) begin
            if (b_adv) begin
                r_dv_tir[j] <= tir_in;
            end
        end
    end

    // Round the mean of the squares to Q1.15 and saturate; total internal reflection gives 1.0
    always_comb begin
        sum = 65'(r_sq1) + 65'(r_sq2) + (65'(1) << 47);
        rnd = sum[64:48];
        if (r_sq_tir || rnd > 17'(frdr_pkg::REFL_ONE)) begin
            n_o_refl = frdr_pkg::REFL_ONE;
        end else begin
            n_o_refl = rnd[frdr_pkg::REFL_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_vld <= 1'b0;
            r_o_vld  <= 1'b0;
        end else if (b_adv) begin
            r_sq_vld <= r_dv_vld[frdr_pkg::DIV_STAGES-1];
            r_o_vld  <= r_sq_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_adv) begin
            r_sq_tir <= r_dv_tir[frdr_pkg::DIV_STAGES-1];
            r_sq1    <= 64'(quo1) * 64'(quo1);
            r_sq2    <= 64'(quo2) * 64'(quo2);
            r_o_tir  <= r_sq_tir;
            r_o_refl <= n_o_refl;
        end
    end

    assign o_result.valid          = r_o_vld;
    assign o_result.reflectance    = r_o_refl;
    assign o_result.total_internal = r_o_tir;

endmodule

// File: rtl/core/fresnel_dielectric_reflectance.sv
// Throughput: one item per cycle while the result channel does not stall the output;
// the square root and both dividers are fully pipelined at one result bit per stage.
// Reset: i_rst_n is synchronous, active low; it empties all stages and the queue
// and loads index_incident = 1.0 and index_transmitted = 1.5.
// ============================================================================
// fresnel_dielectric_reflectance
// Unpolarized Fresnel reflectance of a dielectric boundary: a classifying
// front, a four-entry queue and a pipelined arithmetic back end.
// ============================================================================
module fresnel_dielectric_reflectance (
    input  logic           i_clk,
    input  logic           i_rst_n,
    frdr_item_if.sink      i_item,
    frdr_cfg_if.sink       i_cfg,
    frdr_result_if.source  o_result
);

    logic              push, pop, q_full, q_empty;
    frdr_pkg::t_entry  push_entry, head_entry;

    // Clamp, swap and classify
    frdr_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .i_cfg    (i_cfg),
        .i_q_full (q_full),
        .o_push   (push),
        .o_entry  (push_entry)
    );

    // Decouple front and back
    frdr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_head  (head_entry)
    );

    // Evaluate reflectance
    frdr_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_head    (head_entry),
        .o_pop     (pop),
        .o_result  (o_result)
    );

endmodule
